@@ rtl/shu_pkg.sv @@
// shared types and constants for the signature hint unpacker
package shu_pkg;

	localparam int DEF_MAX_HINTS   = 128;
	localparam int DEF_MAX_POLYS   = 8;
	localparam int COEFFS_PER_POLY = 256;

	localparam int BYTE_W         = 8;
	localparam int WORD_W         = 64;
	localparam int WORDS_PER_POLY = COEFFS_PER_POLY / WORD_W;
	localparam int WORD_IDX_W     = $clog2(WORDS_PER_POLY);
	localparam int BIT_IDX_W      = $clog2(WORD_W);
	localparam int POLY_IDX_W     = 3;
	localparam int POLYS_W        = 4;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_HINT_LIMIT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_POLYS_IN_USE = CFG_IDX_W'(1);

	localparam logic [BYTE_W-1:0]  RST_HINT_LIMIT   = BYTE_W'(80);
	localparam logic [POLYS_W-1:0] RST_POLYS_IN_USE = POLYS_W'(4);

	typedef struct packed {
		logic [BYTE_W-1:0] packed_byte;
		logic              first_of_signature;
	} shu_byte_t;

	typedef struct packed {
		logic [POLY_IDX_W-1:0] poly_index;
		logic [WORD_IDX_W-1:0] word_index;
		logic [WORD_W-1:0]     hint_bits;
		logic                  malformed;
		logic                  last_of_poly;
		logic                  last_of_signature;
	} shu_word_t;

endpackage

@@ rtl/shu_ram.sv @@
// generic single-write, single-read ram with registered read data
module shu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/signature_hint_unpacker.sv @@
// Hint section decoder: takes the packed hint section one byte per transfer. The first
// omega bytes (hint_limit) are coefficient indices and are written to the index store as they
// are taken. Each of the following k count bytes (polys_in_use) walks the store from
// the previous count to this count, one index read per cycle on the store's single read
// port, checking that indices rise strictly; the last count byte also walks the slots up
// to omega and checks that they are zero. A count byte then puts out four 64-bit bitmap
// words, one per cycle while the consumer keeps up; a byte with a bad count or after an
// error skips the walk. The output register lets the next byte be taken while the last
// word waits. Bytes past omega + k are taken and dropped until first_of_signature restarts
// decoding. The index store has no reset and needs no clearing pass.
module signature_hint_unpacker
	import shu_pkg::*;
#(
	parameter int MAX_HINTS = DEF_MAX_HINTS,
	parameter int MAX_POLYS = DEF_MAX_POLYS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  shu_byte_t            byte_item,
	output logic                 word_valid,
	input  logic                 word_ready,
	output shu_word_t            word_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	localparam int AW    = (MAX_HINTS > 1) ? $clog2(MAX_HINTS) : 1;
	localparam int POS_W = $clog2(MAX_HINTS + MAX_POLYS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_EMIT
	} state_t;

	state_t                state_q;
	logic [BYTE_W-1:0]     hint_limit_q;
	logic [POLYS_W-1:0]    polys_in_use_q;
	logic [POS_W-1:0]      pos_q;
	logic [BYTE_W-1:0]     prev_q;
	logic                  err_q;
	logic [BYTE_W-1:0]     cnt_q;
	logic [BYTE_W-1:0]     issue_j_q;
	logic [BYTE_W-1:0]     stop_q;
	logic [BYTE_W-1:0]     last_idx_q;
	logic [POLY_IDX_W-1:0] poly_q;
	logic                  last_poly_q;
	logic [WORD_IDX_W-1:0] word_q;
	logic                  rd_vld_s1;
	logic [BYTE_W-1:0]     rd_j_s1;
	logic                  word_valid_q;
	shu_word_t             word_out_q;
	logic [WORD_W-1:0]     bitmap_q [WORDS_PER_POLY];

	logic                  byte_acc;
	logic [BYTE_W-1:0]     omega;
	logic [POLYS_W-1:0]    k_eff;
	logic [POS_W-1:0]      pos_base;
	logic [POS_W-1:0]      sect_end;
	logic [BYTE_W-1:0]     prev_base;
	logic                  err_base;
	logic                  in_section;
	logic                  is_index;
	logic [POLY_IDX_W-1:0] p_cur;
	logic                  p_last;
	logic [BYTE_W-1:0]     cnt_in;
	logic                  ram_we;
	logic                  ram_re;
	logic [BYTE_W-1:0]     rd_data;
	logic                  in_poly;
	logic                  chk_err;
	logic                  walk_done;
	logic                  out_free;

	assign byte_ready = (state_q == S_IDLE);
	assign byte_acc   = byte_valid && byte_ready;
	assign cfg_ready  = 1'b1;
	assign cnt_in     = byte_item.packed_byte;

	always_comb begin
		omega = (hint_limit_q > BYTE_W'(MAX_HINTS)) ? BYTE_W'(MAX_HINTS) : hint_limit_q;
		if (polys_in_use_q == '0) begin
			k_eff = POLYS_W'(1);
		end else if (polys_in_use_q > POLYS_W'(MAX_POLYS)) begin
			k_eff = POLYS_W'(MAX_POLYS);
		end else begin
			k_eff = polys_in_use_q;
		end
		pos_base   = byte_item.first_of_signature ? '0 : pos_q;
		prev_base  = byte_item.first_of_signature ? '0 : prev_q;
		err_base   = byte_item.first_of_signature ? 1'b0 : err_q;
		sect_end   = POS_W'(omega) + POS_W'(k_eff);
		in_section = pos_base < sect_end;
		is_index   = pos_base < POS_W'(omega);
		p_cur      = POLY_IDX_W'(pos_base - POS_W'(omega));
		p_last     = (POLYS_W'(p_cur) + POLYS_W'(1)) == k_eff;
	end

	assign ram_we = byte_acc && in_section && is_index;
	assign ram_re = (state_q == S_WALK) && (issue_j_q != stop_q);

	shu_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_HINTS)
	) u_index_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_base[AW-1:0]),
		.wdata(byte_item.packed_byte),
		.re   (ram_re),
		.raddr(issue_j_q[AW-1:0]),
		.rdata(rd_data)
	);

	// entries below the count belong to the polynomial, the rest are padding
	assign in_poly   = rd_j_s1 < cnt_q;
	assign chk_err   = rd_vld_s1 && (in_poly
		? ((rd_j_s1 != prev_q) && (rd_data <= last_idx_q))
		: (rd_data != '0));
	assign walk_done = !rd_vld_s1 && (issue_j_q == stop_q);
	assign out_free  = !word_valid_q || word_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			hint_limit_q   <= RST_HINT_LIMIT;
			polys_in_use_q <= RST_POLYS_IN_USE;
			pos_q          <= '0;
			prev_q         <= '0;
			err_q          <= 1'b0;
			cnt_q          <= '0;
			issue_j_q      <= '0;
			stop_q         <= '0;
			last_idx_q     <= '0;
			poly_q         <= '0;
			last_poly_q    <= 1'b0;
			word_q         <= '0;
			rd_vld_s1      <= 1'b0;
			rd_j_s1        <= '0;
			word_valid_q   <= 1'b0;
			word_out_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HINT_LIMIT:   hint_limit_q   <= cfg_data;
					REG_POLYS_IN_USE: polys_in_use_q <= cfg_data[POLYS_W-1:0];
					default:          ;
				endcase
			end

			if (state_q == S_EMIT && out_free) begin
				word_valid_q <= 1'b1;
			end else if (word_ready) begin
				word_valid_q <= 1'b0;
			end

			// a read in flight when the walk is abandoned is dropped
			rd_vld_s1 <= ram_re && !chk_err;
			rd_j_s1   <= issue_j_q;

			case (state_q)
				S_IDLE: begin
					if (byte_acc) begin
						pos_q  <= in_section ? pos_base + POS_W'(1) : pos_base;
						prev_q <= prev_base;
						if (in_section && !is_index) begin
							poly_q      <= p_cur;
							last_poly_q <= p_last;
							word_q      <= '0;
							if (err_base || cnt_in < prev_base || cnt_in > omega) begin
								err_q   <= 1'b1;
								state_q <= S_EMIT;
							end else begin
								err_q     <= 1'b0;
								cnt_q     <= cnt_in;
								issue_j_q <= prev_base;
								stop_q    <= p_last ? omega : cnt_in;
								state_q   <= S_WALK;
							end
						end else begin
							err_q <= err_base;
						end
					end
				end
				S_WALK: begin
					if (ram_re) begin
						issue_j_q <= issue_j_q + BYTE_W'(1);
					end
					if (chk_err) begin
						err_q   <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						if (rd_vld_s1 && in_poly) begin
							last_idx_q <= rd_data;
						end
						if (walk_done) begin
							prev_q  <= cnt_q;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						word_out_q.poly_index        <= poly_q;
						word_out_q.word_index        <= word_q;
						word_out_q.hint_bits         <= err_q ? '0 : bitmap_q[word_q];
						word_out_q.malformed         <= err_q;
						word_out_q.last_of_poly      <= (word_q == WORD_IDX_W'(WORDS_PER_POLY - 1));
						word_out_q.last_of_signature <= (word_q == WORD_IDX_W'(WORDS_PER_POLY - 1))
							&& last_poly_q;
						word_q <= word_q + WORD_IDX_W'(1);
						if (word_q == WORD_IDX_W'(WORDS_PER_POLY - 1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// bitmap of the polynomial being decoded, cleared when its count byte arrives
	always_ff @(posedge clk) begin
		if (byte_acc) begin
			for (int w = 0; w < WORDS_PER_POLY; w++) begin
				bitmap_q[w] <= '0;
			end
		end else if (state_q == S_WALK && rd_vld_s1 && in_poly && !chk_err) begin
			bitmap_q[rd_data[BYTE_W-1 -: WORD_IDX_W]][rd_data[BIT_IDX_W-1:0]] <= 1'b1;
		end
	end

	assign word_valid = word_valid_q;
	assign word_item  = word_out_q;

	a_no_accept_during_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> !byte_ready)
		else $error("byte taken while an index read is in flight");

	a_malformed_zero_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && word_item.malformed) |-> (word_item.hint_bits == '0))
		else $error("hint bits nonzero on a malformed word");

	a_last_sig_is_last_poly: assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && word_item.last_of_signature) |-> word_item.last_of_poly)
		else $error("signature ends off a polynomial boundary");

	a_error_stops_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(err_q) |-> (state_q == S_EMIT))
		else $error("walk continues after an error");

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the signature hint unpacker: byte stimulus, bitmap word scoreboard
`timescale 1ns / 100ps

module tb_top;
	import shu_pkg::*;

	localparam int RESET_CYCLES    = 7;
	localparam int SETTLE_CYCLES   = 200;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int REPORT_LIMIT    = 10;

	typedef enum int {PACE_FULL, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH} pace_t;
	typedef logic [WORDS_PER_POLY-1:0][WORD_W-1:0] poly_map_t;

	class hint_bitmap_board;
		shu_word_t         expected_words[$];
		logic [BYTE_W-1:0] store[DEF_MAX_HINTS];
		int unsigned       limit_reg, polys_reg, pos, prev_cnt, errors;
		bit                bad;

		function new();
			limit_reg = RST_HINT_LIMIT;
			polys_reg = RST_POLYS_IN_USE;
			pos = 0;
			prev_cnt = 0;
			errors = 0;
			bad = 1'b0;
		endfunction

		function int unsigned omega();
			return limit_reg > DEF_MAX_HINTS ? DEF_MAX_HINTS : limit_reg;
		endfunction

		function int unsigned polys();
			if (polys_reg == 0) return 1;
			return polys_reg > DEF_MAX_POLYS ? DEF_MAX_POLYS : polys_reg;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
			if (idx == REG_HINT_LIMIT) limit_reg = data;
			else if (idx == REG_POLYS_IN_USE) polys_reg = data[POLYS_W-1:0];
		endfunction

		// walks the stored indices of one polynomial; sets bad on any failed check
		function poly_map_t walk_poly(int unsigned cnt, int unsigned om, bit closing);
			poly_map_t         map;
			logic [BYTE_W-1:0] idx;
			map = '0;
			if (cnt < prev_cnt || cnt > om) begin
				bad = 1'b1;
				return map;
			end
			for (int unsigned j = prev_cnt; j < cnt; j++) begin
				idx = store[j];
				if (j > prev_cnt && idx <= store[j-1]) begin
					bad = 1'b1;
					return map;
				end
				map[idx[BIT_IDX_W +: WORD_IDX_W]][idx[BIT_IDX_W-1:0]] = 1'b1;
			end
			prev_cnt = cnt;
			// unused slots after the last count must be zero
			if (closing) begin
				for (int unsigned j = cnt; j < om; j++) begin
					if (store[j] != '0) begin
						bad = 1'b1;
						return map;
					end
				end
			end
			return map;
		endfunction

		function void predict_words(shu_byte_t item);
			int unsigned om, k, p;
			bit          closing;
			poly_map_t   map;
			shu_word_t   word;
			om = omega();
			k = polys();
			if (item.first_of_signature) begin
				pos = 0;
				prev_cnt = 0;
				bad = 1'b0;
			end
			if (pos >= om + k) return;
			if (pos < om) begin
				store[pos] = item.packed_byte;
				pos++;
				return;
			end
			p = pos - om;
			closing = (p + 1 == k);
			map = '0;
			if (!bad) map = walk_poly(item.packed_byte, om, closing);
			pos++;
			for (int i = 0; i < WORDS_PER_POLY; i++) begin
				word.poly_index        = POLY_IDX_W'(p);
				word.word_index        = WORD_IDX_W'(i);
				word.hint_bits         = bad ? '0 : map[i];
				word.malformed         = bad;
				word.last_of_poly      = (i == WORDS_PER_POLY - 1);
				word.last_of_signature = (i == WORDS_PER_POLY - 1) && closing;
				expected_words.push_back(word);
			end
		endfunction

		function void note_fault(string what, shu_word_t want, shu_word_t got);
			errors++;
			if (errors <= REPORT_LIMIT) begin
				$display("%s: expected poly %0d word %0d bits %h malformed %b lp %b ls %b",
					what, want.poly_index, want.word_index, want.hint_bits, want.malformed,
					want.last_of_poly, want.last_of_signature);
				$display("    actual poly %0d word %0d bits %h malformed %b lp %b ls %b",
					got.poly_index, got.word_index, got.hint_bits, got.malformed,
					got.last_of_poly, got.last_of_signature);
			end
		endfunction

		function void check_word(shu_word_t got);
			shu_word_t want;
			if (expected_words.size() == 0) begin
				note_fault("word with nothing pending", '0, got);
				return;
			end
			want = expected_words.pop_front();
			if (got.poly_index !== want.poly_index || got.word_index !== want.word_index ||
				got.hint_bits !== want.hint_bits || got.malformed !== want.malformed ||
				got.last_of_poly !== want.last_of_poly ||
				got.last_of_signature !== want.last_of_signature)
				note_fault("bitmap word differs", want, got);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 byte_valid = 1'b0;
	logic                 byte_ready;
	shu_byte_t            byte_item = '0;
	logic                 word_valid;
	logic                 word_ready = 1'b0;
	shu_word_t            word_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_HINT_LIMIT;
	logic [BYTE_W-1:0]    cfg_data = '0;

	hint_bitmap_board board = new();
	pace_t            pace = PACE_FULL;
	bit               hold_words = 1'b0;
	int unsigned      bytes_sent = 0;

	signature_hint_unpacker dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word_item  (word_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_pct();
		case (pace)
			PACE_SENDER_GAPS: return 68;
			PACE_BOTH:        return 19;
			default:          return 0;
		endcase
	endfunction

	function automatic int stall_pct();
		case (pace)
			PACE_RECEIVER_STALLS: return 68;
			PACE_BOTH:            return 19;
			default:              return 0;
		endcase
	endfunction

	// receiver side; a hold request keeps ready low for a long stretch
	initial begin
		forever begin
			@(negedge clk);
			if (hold_words) begin
				word_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_words = 1'b0;
			end else begin
				word_ready <= ($urandom_range(99) >= stall_pct());
			end
		end
	end

	always @(posedge clk)
		if (arst_n && word_valid && word_ready) board.check_word(word_item);

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((byte_valid && byte_ready) || (word_valid && word_ready) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_byte(input logic [BYTE_W-1:0] value, input bit first);
		shu_byte_t item;
		item.packed_byte = value;
		item.first_of_signature = first;
		while ($urandom_range(99) < gap_pct()) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= item;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		board.predict_words(item);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(negedge clk);
		while (board.expected_words.size() != 0) @(negedge clk);
	endtask

	task automatic set_config(input logic [BYTE_W-1:0] limit, input logic [BYTE_W-1:0] polys);
		wait_drained();
		// an index byte has no word to wait for, so give the walk time to finish
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_HINT_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(REG_HINT_LIMIT, limit);
		@(negedge clk);
		cfg_index <= REG_POLYS_IN_USE;
		cfg_data <= polys;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(REG_POLYS_IN_USE, polys);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one hint section with random content, now and then damaged, cut short or overlong
	task automatic send_section(input bit restart);
		int unsigned       om, k, h, n, victim, kind, stop, base;
		int unsigned       counts[$];
		logic [BYTE_W-1:0] indices[$];
		logic [BYTE_W-1:0] bytes[$];
		logic [255:0]      chosen;
		om = board.omega();
		k = board.polys();
		case ($urandom_range(3))
			0:       h = om;
			1:       h = $urandom_range(om < 3 ? om : 3, 0);
			default: h = $urandom_range(om, 0);
		endcase
		for (int i = 0; i < k - 1; i++) counts.push_back($urandom_range(h, 0));
		counts.sort();
		counts.push_back(h);
		for (int i = 0; i < k; i++) begin
			base = (i == 0) ? 0 : counts[i-1];
			n = counts[i] - base;
			chosen = '0;
			while ($countones(chosen) < n) chosen[$urandom_range(255)] = 1'b1;
			for (int c = 0; c < 256; c++)
				if (chosen[c]) indices.push_back(BYTE_W'(c));
		end
		while (indices.size() < om) indices.push_back('0);
		kind = ($urandom_range(3) == 0) ? $urandom_range(5, 1) : 0;
		case (kind)
			1: if (h >= 2) begin
				victim = $urandom_range(h - 1, 1);
				indices[victim] = BYTE_W'($urandom_range(indices[victim-1], 0));
			end
			2: if (h < om) indices[$urandom_range(om - 1, h)] = BYTE_W'($urandom_range(255, 1));
			3: if (k > 1) begin
				victim = $urandom_range(k - 1, 1);
				if (counts[victim-1] > 0) counts[victim] = $urandom_range(counts[victim-1] - 1, 0);
			end
			4: if (om < 255) counts[$urandom_range(k - 1, 0)] = $urandom_range(255, om + 1);
			default: ;
		endcase
		bytes = indices;
		for (int i = 0; i < k; i++) bytes.push_back(BYTE_W'(counts[i]));
		if (kind == 5) bytes[$urandom_range(bytes.size() - 1)] = BYTE_W'($urandom);
		// bytes past the end of the section are dropped by the block
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(2, 1)) bytes.push_back(BYTE_W'($urandom));
		stop = bytes.size();
		if ($urandom_range(9) == 0) stop = $urandom_range(bytes.size() - 1, 1);
		for (int i = 0; i < stop; i++) send_byte(bytes[i], restart && i == 0);
	endtask

	task automatic play_sections(input int unsigned budget);
		int unsigned start;
		start = bytes_sent;
		// a section right after a register write always restarts the decoder
		send_section(1'b1);
		while (bytes_sent - start < budget) begin
			case ($urandom_range(9))
				0:       repeat ($urandom_range(6, 1))
					send_byte(BYTE_W'($urandom), $urandom_range(3) == 0);
				1:       send_section(1'b0);
				default: send_section(1'b1);
			endcase
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_config(3, 2);
		// both extreme indices, then a repeated index, nonzero padding,
		// a falling count with a dropped extra byte, and a count above the limit
		send_byte(0, 1); send_byte(63, 0); send_byte(255, 0); send_byte(2, 0); send_byte(3, 0);
		send_byte(64, 1); send_byte(64, 0); send_byte(0, 0); send_byte(2, 0); send_byte(3, 0);
		send_byte(5, 1); send_byte(0, 0); send_byte(7, 0); send_byte(1, 0); send_byte(1, 0);
		send_byte(10, 1); send_byte(20, 0); send_byte(0, 0); send_byte(2, 0); send_byte(1, 0);
		send_byte(255, 0);
		send_byte(1, 1); send_byte(2, 0); send_byte(3, 0); send_byte(4, 0); send_byte(3, 0);

		set_config(4, 4);
		pace = PACE_FULL;
		hold_words = 1'b1;
		play_sections(20);

		set_config(6, 3);
		pace = PACE_SENDER_GAPS;
		play_sections(20);

		set_config(8, 2);
		pace = PACE_RECEIVER_STALLS;
		play_sections(10);
		wait_drained();
		play_sections(10);

		set_config(1, 0);
		pace = PACE_BOTH;
		play_sections(20);

		set_config(2, 12);
		pace = PACE_BOTH;
		play_sections(20);

		set_config(128, 8);
		pace = PACE_RECEIVER_STALLS;
		play_sections(136);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.expected_words.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
